@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent check forms. Each expects clk and rst in the calling scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMP(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("%m: implication check failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("%m: next-cycle check failed");

`endif

@@ rtl/core/ptw_pkg.sv @@
// ----------------------------------------------------------------------------
// ptw_pkg
// Types and constants shared by the page table walker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ptw_pkg;

  localparam int PHYS_W          = 52;   // width of physical addresses out
  localparam int VA_W            = 48;   // width of the walk address
  localparam int PHYS_BITS_DEF   = 36;   // implemented physical address bits
  localparam int QUEUE_DEPTH_DEF = 2;    // front-to-back queue depth

  // Input word kinds
  localparam logic KIND_REQ   = 1'b0;    // translate request
  localparam logic KIND_ENTRY = 1'b1;    // table entry from memory

  // Result word kinds
  localparam logic RES_READ = 1'b0;      // memory read request
  localparam logic RES_DONE = 1'b1;      // translation finished

  // Walk level: idle, or waiting for the entry of that level
  typedef enum logic [2:0] {
    LVL_IDLE = 3'd0,
    LVL_1    = 3'd1,
    LVL_2    = 3'd2,
    LVL_3    = 3'd3,
    LVL_4    = 3'd4
  } ptw_level_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] table_root;
    logic [47:0] virt_addr;
    logic [31:0] addr_offset;
    logic [63:0] entry_data;
  } ptw_in_t;

  typedef struct packed {
    logic              result_kind;
    logic [63:0]       read_address;
    logic [PHYS_W-1:0] phys_address;
  } ptw_out_t;

  // Classified word handed from the front to the back
  typedef struct packed {
    logic              kind;
    logic              invalid;     // zero root or zero virtual address
    logic [63:0]       root_base;   // root with low 4 bits cleared
    logic [VA_W-1:0]   walk_sum;    // virt_addr + offset, mod 2^48
    logic              present;     // entry bit 0
    logic              large_page;  // entry bit 7
    logic [PHYS_W-1:0] frame;       // entry bits 12..PHYS_BITS-1
    logic              frame_zero;
  } ptw_work_t;

endpackage

`default_nettype wire

@@ rtl/core/ptw_front.sv @@
// ----------------------------------------------------------------------------
// ptw_front
// Accepts input words and precomputes everything that does not depend on
// walk state: request validity, walk address sum, masked entry frame.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_front #(
  parameter int PHYS_BITS = ptw_pkg::PHYS_BITS_DEF
) (
  input  ptw_pkg::ptw_in_t   item,
  input  logic               item_valid,
  output logic               item_ready,
  output ptw_pkg::ptw_work_t work,
  output logic               work_valid,
  input  logic               work_ready
);
  import ptw_pkg::*;

  // Bits 12..PHYS_BITS-1 set
  localparam logic [PHYS_W-1:0] PHYS_MASK  = (PHYS_W'(1) << PHYS_BITS) - PHYS_W'(1);
  localparam logic [PHYS_W-1:0] FRAME_MASK = PHYS_MASK & ~PHYS_W'(12'hFFF);

  logic [PHYS_W-1:0] frame;

  // Pass-through handshake into the queue
  assign work_valid = item_valid;
  assign item_ready = work_ready;

  // Classify the word
  always_comb begin
    frame           = item.entry_data[PHYS_W-1:0] & FRAME_MASK;
    work.kind       = item.kind;
    work.invalid    = (item.table_root == 64'd0) || (item.virt_addr == '0);
    work.root_base  = {item.table_root[63:4], 4'b0000};
    work.walk_sum   = item.virt_addr + VA_W'(item.addr_offset);
    work.present    = item.entry_data[0];
    work.large_page = item.entry_data[7];
    work.frame      = frame;
    work.frame_zero = (frame == '0);
  end

endmodule

`default_nettype wire

@@ rtl/core/ptw_queue.sv @@
// ----------------------------------------------------------------------------
// ptw_queue
// Short register FIFO between front and back; each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ptw_queue #(
  parameter int DEPTH = ptw_pkg::QUEUE_DEPTH_DEF   // 2 or more
) (
  input  logic               clk,
  input  logic               rst,
  input  ptw_pkg::ptw_work_t push_data,
  input  logic               push_valid,
  output logic               push_ready,
  output ptw_pkg::ptw_work_t pop_data,
  output logic               pop_valid,
  input  logic               pop_ready
);
  import ptw_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ptw_work_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `ASSERT_IMP(a_count_bound, 1'b1, count <= CNT_W'(DEPTH))
  `ASSERT_NXT(a_count_up, push && !pop, count == $past(count) + CNT_W'(1))
  `ASSERT_IMP(a_ptrs_empty, count == '0, wr_ptr == rd_ptr)

endmodule

`default_nettype wire

@@ rtl/core/ptw_back.sv @@
// ----------------------------------------------------------------------------
// ptw_back
// Walk state machine: applies classified words to the walk level and address
// and drives the registered result word.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ptw_back (
  input  logic               clk,
  input  logic               rst,
  input  ptw_pkg::ptw_work_t work,
  input  logic               work_valid,
  output logic               work_ready,
  output ptw_pkg::ptw_out_t  result,
  output logic               result_valid,
  input  logic               result_ready
);
  import ptw_pkg::*;

  ptw_level_t      level;
  ptw_level_t      level_next;
  logic [VA_W-1:0] walk_addr;
  logic [VA_W-1:0] walk_addr_next;
  ptw_out_t        res_next;
  logic            emit;
  logic            busy;
  logic            take;
  logic [8:0]      next_idx;

  // Output slot free or draining this cycle
  assign work_ready = !result_valid || result_ready;
  assign take       = work_valid && work_ready;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      level     <= LVL_IDLE;
      walk_addr <= '0;
    end else if (take) begin
      level     <= level_next;
      walk_addr <= walk_addr_next;
    end
  end

  // Next state and result word
  always_comb begin
    level_next     = level;
    walk_addr_next = walk_addr;
    emit           = 1'b0;
    res_next       = '0;
    next_idx       = '0;

    busy = (level inside {LVL_1, LVL_2, LVL_3, LVL_4});

    // Table index of the level after the current one
    case (level)
      LVL_1:   next_idx = walk_addr[38:30];
      LVL_2:   next_idx = walk_addr[29:21];
      LVL_3:   next_idx = walk_addr[20:12];
      default: next_idx = '0;
    endcase

    if (work.kind == KIND_REQ) begin
      // Requests while busy are dropped
      if (!busy) begin
        emit = 1'b1;
        if (work.invalid) begin
          level_next           = LVL_IDLE;
          res_next.result_kind = RES_DONE;
        end else begin
          level_next            = LVL_1;
          walk_addr_next        = work.walk_sum;
          res_next.result_kind  = RES_READ;
          res_next.read_address = work.root_base + {52'd0, work.walk_sum[47:39], 3'b000};
        end
      end
    end else if (!busy) begin
      // Stray entry: drop, fold unused codes back to idle
      level_next = LVL_IDLE;
    end else begin
      emit                 = 1'b1;
      res_next.result_kind = RES_DONE;
      level_next           = LVL_IDLE;
      if (!work.present) begin
        res_next.phys_address = '0;
      end else if (level == LVL_2 && work.large_page) begin
        // 1 GiB page
        res_next.phys_address = {work.frame[PHYS_W-1:30], walk_addr[29:0]};
      end else if (level == LVL_3 && work.large_page) begin
        // 2 MiB page
        res_next.phys_address = {work.frame[PHYS_W-1:21], walk_addr[20:0]};
      end else if (level == LVL_4) begin
        res_next.phys_address = work.frame_zero ? '0 :
                                {work.frame[PHYS_W-1:12], walk_addr[11:0]};
      end else begin
        // Descend one level; frame low 12 bits are clear, so OR is the add
        res_next.result_kind  = RES_READ;
        res_next.read_address = {12'd0, work.frame[PHYS_W-1:12], next_idx, 3'b000};
        case (level)
          LVL_1:   level_next = LVL_2;
          LVL_2:   level_next = LVL_3;
          default: level_next = LVL_4;
        endcase
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (work_ready) begin
      result_valid <= take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      result <= res_next;
    end
  end

  `ASSERT_NXT(a_read_busy, take && emit && res_next.result_kind == RES_READ, level != LVL_IDLE)
  `ASSERT_NXT(a_done_idle, take && emit && res_next.result_kind == RES_DONE, level == LVL_IDLE)
  `ASSERT_IMP(a_done_no_read, result_valid && result.result_kind == RES_DONE,
              result.read_address == 64'd0)

endmodule

`default_nettype wire

@@ rtl/core/four_level_page_table_walker.sv @@
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Four-level 4 KiB page walker with 2 MiB and 1 GiB large pages.
// ----------------------------------------------------------------------------
// Takes one word per cycle on the item channel while the queue has room:
// a translate request or a table entry returned by memory. Each word gives
// at most one result word, either a read request for the next table entry
// or a finished translation (phys_address 0 on a fault or an invalid
// request). A word's result is written to the result register after the
// word has passed through the front queue and the walk state machine,
// which handles one word per cycle while its result register is free or
// being taken. The queue holds QUEUE_DEPTH words, so until it fills the item
// channel keeps accepting while a result waits to be taken. Requests that
// arrive during a walk and idle-time entries are consumed without a result.
`default_nettype none

module four_level_page_table_walker #(
  parameter int PHYS_BITS   = ptw_pkg::PHYS_BITS_DEF,   // 13..52
  parameter int QUEUE_DEPTH = ptw_pkg::QUEUE_DEPTH_DEF  // 2 or more
) (
  input  logic              clk,
  input  logic              rst,
  input  ptw_pkg::ptw_in_t  item,
  input  logic              item_valid,
  output logic              item_ready,
  output ptw_pkg::ptw_out_t result,
  output logic              result_valid,
  input  logic              result_ready
);
  import ptw_pkg::*;

  ptw_work_t front_word;
  logic      front_valid;
  logic      front_ready;
  ptw_work_t back_word;
  logic      back_valid;
  logic      back_ready;

  // Classification
  ptw_front #(
    .PHYS_BITS (PHYS_BITS)
  ) u_front (
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .work       (front_word),
    .work_valid (front_valid),
    .work_ready (front_ready)
  );

  // Decoupling queue
  ptw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (front_word),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_data   (back_word),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  // Walk execution
  ptw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .work         (back_word),
    .work_valid   (back_valid),
    .work_ready   (back_ready),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule

`default_nettype wire

@@ verif/four_level_page_table_walker_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker_tb
// Self-checking bench for the four-level page walker. A local walk model
// follows every accepted input word and queues the result word it must
// produce. A monitor compares each result word field by field. Stimulus is
// directed corner cases, then mostly well-formed walks with random content,
// mixed with noise, random idling on both sides and a long result stall.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_tb;
  import ptw_pkg::*;

  localparam int PHYS_BITS     = PHYS_BITS_DEF;
  localparam int HOLD_CYCLES   = 300;  // long result stall
  localparam int SETTLE_CYCLES = 20;   // well past the result latency
  localparam int IDLE_PCT      = 13;

  // How a well-formed walk ends
  typedef enum int {
    END_FAULT,
    END_1G,
    END_2M,
    END_4K_EMPTY,
    END_4K
  } walk_end_t;

  logic     clk          = 1'b0;
  logic     rst          = 1'b1;
  ptw_in_t  item         = '0;
  logic     item_valid   = 1'b0;
  logic     item_ready;
  ptw_out_t result;
  logic     result_valid;
  logic     result_ready = 1'b0;

  four_level_page_table_walker dut (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

  // Walk model state
  ptw_level_t      walk_lvl = LVL_IDLE;
  logic [VA_W-1:0] walk_va  = '0;
  ptw_out_t        pending_walk_results[$];

  int idle_pct     = IDLE_PCT;
  bit hold_request = 1'b0;

  int errors          = 0;
  int words_sent      = 0;
  int results_checked = 0;
  int pages_1g        = 0;
  int pages_2m        = 0;
  int pages_4k        = 0;
  int zero_results    = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bits lo..PHYS_BITS-1 of a table entry
  function automatic logic [63:0] frame_bits(input int lo);
    return ((64'd1 << PHYS_BITS) - 64'd1) & ~((64'd1 << lo) - 64'd1);
  endfunction

  // 9-bit table index of the walk address for a level
  function automatic logic [63:0] table_index(input ptw_level_t lvl,
                                              input logic [VA_W-1:0] va);
    int shift;
    shift = 39 - 9 * (int'(lvl) - 1);
    return {55'd0, va[shift +: 9]};
  endfunction

  // Advance the walk model by one accepted word; queue the result it causes
  task automatic translate_step(input ptw_in_t w);
    ptw_out_t    r;
    logic [63:0] e;
    bit          emit;
    r    = '0;
    emit = 1'b0;
    e    = w.entry_data;
    if (w.kind == KIND_REQ) begin
      // requests during a walk are dropped
      if (walk_lvl == LVL_IDLE) begin
        emit = 1'b1;
        if (w.table_root == '0 || w.virt_addr == '0) begin
          r.result_kind = RES_DONE;
        end else begin
          walk_va         = w.virt_addr + VA_W'(w.addr_offset);
          walk_lvl        = LVL_1;
          r.result_kind   = RES_READ;
          r.read_address  = {w.table_root[63:4], 4'h0} +
                            64'd8 * table_index(LVL_1, walk_va);
        end
      end
    end else if (walk_lvl != LVL_IDLE) begin
      emit          = 1'b1;
      r.result_kind = RES_DONE;
      if (e[0] && walk_lvl == LVL_2 && e[7]) begin
        r.phys_address = PHYS_W'((e & frame_bits(30)) + {34'd0, walk_va[29:0]});
        pages_1g++;
      end else if (e[0] && walk_lvl == LVL_3 && e[7]) begin
        r.phys_address = PHYS_W'((e & frame_bits(21)) + {43'd0, walk_va[20:0]});
        pages_2m++;
      end else if (e[0] && walk_lvl == LVL_4 && (e & frame_bits(12)) != '0) begin
        r.phys_address = PHYS_W'((e & frame_bits(12)) + {52'd0, walk_va[11:0]});
        pages_4k++;
      end else if (e[0] && walk_lvl != LVL_4) begin
        walk_lvl       = ptw_level_t'(walk_lvl + 3'd1);
        r.result_kind  = RES_READ;
        r.read_address = (e & frame_bits(12)) + 64'd8 * table_index(walk_lvl, walk_va);
      end
      // otherwise a fault or an empty last-level frame: result stays zero
    end
    if (emit) begin
      if (r.result_kind == RES_DONE) begin
        walk_lvl = LVL_IDLE;
        if (r.phys_address == '0)
          zero_results++;
      end
      pending_walk_results.push_back(r);
    end
  endtask

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
    end
  endtask

  // Input monitor feeds the model; result monitor checks against it
  always @(posedge clk) begin : result_mon
    ptw_out_t want;
    if (!rst) begin
      if (item_valid && item_ready)
        translate_step(item);
      if (result_valid && result_ready) begin
        if (pending_walk_results.size() == 0) begin
          errors++;
          $display("%0t: result word with none expected: expected none, actual %h",
                   $time, result);
        end else begin
          want = pending_walk_results.pop_front();
          results_checked++;
          check_field("result_kind", 64'(want.result_kind), 64'(result.result_kind));
          check_field("read_address", want.read_address, result.read_address);
          check_field("phys_address", 64'(want.phys_address), 64'(result.phys_address));
        end
      end
    end
  end

  // Result side: random stalls, or one long hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        result_ready <= 1'b0;
        for (int i = 0; i < HOLD_CYCLES; i++)
          @(posedge clk);
      end else begin
        result_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Offer one word after a random gap; valid stays high once raised
  task automatic send_word(input ptw_in_t w);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item       <= w;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready)
      @(posedge clk);
    words_sent++;
  endtask

  function automatic ptw_in_t random_word(input logic kind);
    ptw_in_t w;
    w.kind        = kind;
    w.table_root  = {$urandom, $urandom};
    w.virt_addr   = VA_W'({$urandom, $urandom});
    w.addr_offset = $urandom;
    w.entry_data  = {$urandom, $urandom};
    return w;
  endfunction

  // One request followed by the entries for each level up to the chosen end
  task automatic run_walk(input walk_end_t how, input int fault_lvl);
    ptw_in_t w;
    int      last_lvl;
    case (how)
      END_FAULT: last_lvl = fault_lvl;
      END_1G:    last_lvl = 2;
      END_2M:    last_lvl = 3;
      default:   last_lvl = 4;
    endcase
    w = random_word(KIND_REQ);
    if (w.table_root == '0)
      w.table_root[63] = 1'b1;
    if (w.virt_addr == '0)
      w.virt_addr[0] = 1'b1;
    send_word(w);
    for (int lvl = 1; lvl <= last_lvl; lvl++) begin
      // now and then a request cuts into the walk and is dropped
      if ($urandom_range(19) == 0)
        send_word(random_word(KIND_REQ));
      w = random_word(KIND_ENTRY);
      w.entry_data[0] = 1'b1;
      if (lvl == last_lvl) begin
        case (how)
          END_FAULT:      w.entry_data[0] = 1'b0;
          END_1G, END_2M: w.entry_data[7] = 1'b1;
          END_4K_EMPTY:   w.entry_data[PHYS_BITS-1:12] = '0;
          default: ;
        endcase
      end else if (lvl == 2 || lvl == 3) begin
        w.entry_data[7] = 1'b0;
      end
      send_word(w);
    end
  endtask

  task automatic random_walk();
    run_walk(walk_end_t'($urandom_range(4)), $urandom_range(1, 4));
  endtask

  // Random words of either kind, then a non-present entry to get back to idle
  task automatic noise_burst();
    ptw_in_t w;
    repeat ($urandom_range(1, 4)) begin
      w = random_word(1'($urandom_range(1)));
      if (w.kind == KIND_REQ && $urandom_range(3) == 0) begin
        if ($urandom_range(1)) w.table_root = '0;
        else                   w.virt_addr  = '0;
      end
      send_word(w);
    end
    w = random_word(KIND_ENTRY);
    w.entry_data[0] = 1'b0;
    send_word(w);
  endtask

  task automatic test_directed();
    ptw_in_t w;
    // invalid requests: zero root, zero address, everything zero
    w = random_word(KIND_REQ);
    w.table_root = '0;
    send_word(w);
    w = random_word(KIND_REQ);
    w.virt_addr = '0;
    send_word(w);
    w = '0;
    w.kind = KIND_REQ;
    send_word(w);
    // entry while idle is dropped
    w = '1;
    w.kind = KIND_ENTRY;
    send_word(w);
    // top index 0x1ff under an all-ones root: read address wraps
    w = '1;
    w.kind = KIND_REQ;
    w.addr_offset = '0;
    send_word(w);
    // all-ones request while busy is dropped
    w = '1;
    w.kind = KIND_REQ;
    send_word(w);
    // all-ones entries: level 1 goes on, level 2 ends at a 1 GiB page
    w = '1;
    w.kind = KIND_ENTRY;
    send_word(w);
    send_word(w);
    // root 1 gives base 0; present-only entries lead to a 2 MiB page at frame 0
    w = '0;
    w.kind = KIND_REQ;
    w.table_root = 64'd1;
    w.virt_addr = 48'd1;
    send_word(w);
    w = '0;
    w.kind = KIND_ENTRY;
    w.entry_data = 64'h1;
    send_word(w);
    send_word(w);
    w.entry_data = 64'h81;
    send_word(w);
    // full walks to a 4 KiB page and to an empty last-level frame
    run_walk(END_4K, 0);
    run_walk(END_4K_EMPTY, 0);
  endtask

  task automatic test_random_walks(input int count);
    int target;
    target = words_sent + count;
    while (words_sent < target) begin
      if ($urandom_range(4) == 0) noise_burst();
      else                        random_walk();
    end
  endtask

  task automatic test_no_idle(input int count);
    idle_pct = 0;
    test_random_walks(count);
    idle_pct = IDLE_PCT;
  endtask

  // Results held back while words keep coming, so the input side stalls
  task automatic test_backpressure(input int count);
    hold_request = 1'b1;
    test_random_walks(count);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_walks(700);
    test_no_idle(200);
    test_backpressure(60);
    test_random_walks(520);

    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_walk_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d words, checked %0d result words (idle gaps, no-idle run, long stall)",
             words_sent, results_checked);
    $display("Walk ends: %0d 1 GiB, %0d 2 MiB, %0d 4 KiB pages, %0d zero results",
             pages_1g, pages_2m, pages_4k, zero_results);
    if (errors == 0) begin
      $display("four_level_page_table_walker_tb OK");
    end else begin
      $display("four_level_page_table_walker_tb NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("four_level_page_table_walker_tb NOT OK");
    $finish;
  end

endmodule
